>>> sv/bad_pkg.sv
package bad_pkg;

  // Field and register widths fixed by the interface.
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int CH_W        = 3;
  localparam int RAW_FACT_W  = 5;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int SUM_W       = 16;
  localparam int LANE_COUNT  = 4;
  localparam int ACC_W       = SUM_W * LANE_COUNT;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEFAULT_MAX_OUT_COLUMNS = 4096;
  localparam int DEFAULT_MAX_FACTOR      = 16;

  localparam logic [DIM_W-1:0] SOURCE_LIMIT = DIM_W'(4096);

  localparam logic [DIM_W-1:0]      RESET_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0]      RESET_HEIGHT   = DIM_W'(480);
  localparam logic [RAW_FACT_W-1:0] RESET_FACTOR   = RAW_FACT_W'(4);
  localparam logic [CH_W-1:0]       RESET_CHANNELS = CH_W'(3);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SHRINK_FACTOR = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
    logic [7:0] pixel_c3;
  } pixel_t;

  typedef struct packed {
    logic [7:0] avg_c0;
    logic [7:0] avg_c1;
    logic [7:0] avg_c2;
    logic [7:0] avg_c3;
    logic       image_done;
  } result_t;

  // Clamped image geometry as the front end sees it.
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

  // One accumulate operation handed from the front end to the back end.
  typedef struct packed {
    pixel_t           pixel;
    logic [POS_W-1:0] block_col;
    logic             emit;
    logic             last;
  } op_t;

  typedef enum logic [1:0] {
    FR_START,
    FR_WAIT,
    FR_RUN
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > SOURCE_LIMIT) begin
      r = SOURCE_LIMIT;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] clamp_channels(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CH_W'(1);
    end else if (v > CH_W'(LANE_COUNT)) begin
      r = CH_W'(LANE_COUNT);
    end
    return r;
  endfunction

  function automatic logic [7:0] pixel_byte(input pixel_t p, input int unsigned c);
    logic [7:0] b;
    case (c)
      0: b = p.pixel_c0;
      1: b = p.pixel_c1;
      2: b = p.pixel_c2;
      3: b = p.pixel_c3;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> sv/bad_divider.sv
module bad_divider #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> sv/bad_fifo.sv
module bad_fifo
  import bad_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  assign head_op = entries[rd_ptr];
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule

>>> sv/bad_front.sv
module bad_front
  import bad_pkg::*;
#(
  parameter int MAX_OUT_COLUMNS = DEFAULT_MAX_OUT_COLUMNS,
  parameter int MAX_FACTOR      = DEFAULT_MAX_FACTOR,
  localparam int FACT_W         = $clog2(MAX_FACTOR + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              resync,
  input  geom_t             geom,
  input  logic [FACT_W-1:0] factor,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_stall,
  input  pixel_t            in_data,
  output logic              q_push,
  output op_t               q_op,
  input  logic              q_full
);

  front_state_t state;
  front_state_t state_next;

  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [FACT_W-1:0] cc;
  logic [FACT_W-1:0] rr;
  logic [POS_W-1:0]  bc;
  logic [POS_W-1:0]  br;
  logic [DIM_W-1:0]  out_cols;
  logic [DIM_W-1:0]  out_rows;

  logic              div_start;
  logic              div_busy;
  logic [DIM_W-1:0]  w_quot;
  logic [DIM_W-1:0]  h_quot;
  logic [DIM_W-1:0]  c_quot;
  logic [DIM_W-1:0]  r_quot;
  logic [FACT_W-1:0] c_rem;
  logic [FACT_W-1:0] r_rem;

  logic in_ready;
  logic accept;
  logic in_range;
  logic col_end;
  logic row_end;
  logic col_wrap;
  logic row_wrap;

  // Four dividers run side by side to rebuild the block geometry and the
  // position within the block whenever the configuration changes.
  bad_divider #(.NUM_W(DIM_W), .DEN_W(FACT_W)) u_div_w (
    .clk(clk), .rst(rst), .start(div_start), .num(geom.width), .den(factor),
    .busy(div_busy), .quotient(w_quot), .remainder()
  );
  bad_divider #(.NUM_W(DIM_W), .DEN_W(FACT_W)) u_div_h (
    .clk(clk), .rst(rst), .start(div_start), .num(geom.height), .den(factor),
    .busy(), .quotient(h_quot), .remainder()
  );
  bad_divider #(.NUM_W(DIM_W), .DEN_W(FACT_W)) u_div_c (
    .clk(clk), .rst(rst), .start(div_start), .num({1'b0, col}), .den(factor),
    .busy(), .quotient(c_quot), .remainder(c_rem)
  );
  bad_divider #(.NUM_W(DIM_W), .DEN_W(FACT_W)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .num({1'b0, row}), .den(factor),
    .busy(), .quotient(r_quot), .remainder(r_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      FR_START: state_next = FR_WAIT;
      FR_WAIT:  if (!div_busy) state_next = FR_RUN;
      FR_RUN:   state_next = FR_RUN;
      default:  state_next = FR_START;
    endcase
    if (resync) begin
      state_next = FR_START;
    end
  end

  always_comb begin
    div_start = (state == FR_START);
    in_ready  = (state == FR_RUN) && !q_full && !clearing && !resync;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_START;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = !in_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_range = ({1'b0, bc} < out_cols) && ({1'b0, br} < out_rows);
    col_end  = (cc == factor - FACT_W'(1));
    row_end  = (rr == factor - FACT_W'(1));
    col_wrap = ({1'b0, col} + DIM_W'(1) >= geom.width);
    row_wrap = ({1'b0, row} + DIM_W'(1) >= geom.height);
  end

  always_comb begin
    q_push         = accept && in_range;
    q_op.pixel     = in_data;
    q_op.block_col = bc;
    q_op.emit      = col_end && row_end;
    q_op.last      = ({1'b0, bc} == out_cols - DIM_W'(1)) &&
                     ({1'b0, br} == out_rows - DIM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      cc       <= '0;
      rr       <= '0;
      bc       <= '0;
      br       <= '0;
      out_cols <= '0;
      out_rows <= '0;
    end else if (state == FR_WAIT && !div_busy) begin
      cc       <= c_rem;
      rr       <= r_rem;
      bc       <= c_quot[POS_W-1:0];
      br       <= r_quot[POS_W-1:0];
      out_cols <= (32'(w_quot) > MAX_OUT_COLUMNS) ? DIM_W'(MAX_OUT_COLUMNS) : w_quot;
      out_rows <= h_quot;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        cc  <= '0;
        bc  <= '0;
        if (row_wrap) begin
          row <= '0;
          rr  <= '0;
          br  <= '0;
        end else begin
          row <= row + POS_W'(1);
          if (row_end) begin
            rr <= '0;
            br <= br + POS_W'(1);
          end else begin
            rr <= rr + FACT_W'(1);
          end
        end
      end else begin
        col <= col + POS_W'(1);
        if (col_end) begin
          cc <= '0;
          bc <= bc + POS_W'(1);
        end else begin
          cc <= cc + FACT_W'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == FR_RUN) |-> (cc < factor) && (rr < factor))
    else $error("position within block out of range");

endmodule

>>> sv/bad_back.sv
module bad_back
  import bad_pkg::*;
#(
  parameter int MAX_OUT_COLUMNS = DEFAULT_MAX_OUT_COLUMNS,
  parameter int MAX_FACTOR      = DEFAULT_MAX_FACTOR,
  localparam int FACT_W         = $clog2(MAX_FACTOR + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CH_W-1:0]   channels,
  input  logic [FACT_W-1:0] factor,
  input  logic              q_empty,
  input  op_t               q_op,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output result_t           out_data
);

  localparam int ADDR_W = $clog2(MAX_OUT_COLUMNS);
  localparam int NSQ_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

  back_state_t state;
  back_state_t state_next;

  logic [ACC_W-1:0]  sums [MAX_OUT_COLUMNS];
  logic [ACC_W-1:0]  rd_data;
  logic [ADDR_W-1:0] clr_cnt;
  op_t               op;

  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ACC_W-1:0]  mem_wdata;

  logic [ACC_W-1:0]  new_sum;
  logic [NSQ_W-1:0]  block_area;
  logic              div_start;
  logic [LANE_COUNT-1:0] div_busy;
  logic [SUM_W-1:0]  quot [LANE_COUNT];
  logic [7:0]        avg [LANE_COUNT];
  logic              load;

  always_comb begin
    for (int c = 0; c < LANE_COUNT; c++) begin
      new_sum[c*SUM_W +: SUM_W] = rd_data[c*SUM_W +: SUM_W];
      if (CH_W'(c) < channels) begin
        new_sum[c*SUM_W +: SUM_W] = rd_data[c*SUM_W +: SUM_W] +
                                    SUM_W'(pixel_byte(op.pixel, c));
      end
    end
    block_area = NSQ_W'(factor) * NSQ_W'(factor);
  end

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    bad_divider #(.NUM_W(SUM_W), .DEN_W(NSQ_W)) u_div (
      .clk(clk), .rst(rst), .start(div_start),
      .num(new_sum[g*SUM_W +: SUM_W]), .den(block_area),
      .busy(div_busy[g]), .quotient(quot[g]), .remainder()
    );
    assign avg[g] = (CH_W'(g) >= channels) ? 8'd0 :
                    (quot[g] > SUM_W'(255)) ? 8'd255 : quot[g][7:0];
  end

  assign load = (state == BK_DIVIDE) && (div_busy == '0) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR:  if (clr_cnt == ADDR_W'(MAX_OUT_COLUMNS - 1)) state_next = BK_IDLE;
      BK_IDLE:   if (!q_empty) state_next = BK_UPDATE;
      BK_UPDATE: state_next = op.emit ? BK_DIVIDE : BK_IDLE;
      BK_DIVIDE: if (load) state_next = BK_IDLE;
      default:   state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = (state == BK_CLEAR);
    q_pop     = (state == BK_IDLE) && !q_empty;
    mem_re    = q_pop;
    mem_raddr = ADDR_W'(q_op.block_col);
    mem_we    = (state == BK_CLEAR) || (state == BK_UPDATE);
    mem_waddr = (state == BK_CLEAR) ? clr_cnt : ADDR_W'(op.block_col);
    mem_wdata = (state == BK_UPDATE && !op.emit) ? new_sum : '0;
    div_start = (state == BK_UPDATE) && op.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == BK_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= sums[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.avg_c0     <= avg[0];
      out_data.avg_c1     <= avg[1];
      out_data.avg_c2     <= avg[2];
      out_data.avg_c3     <= avg[3];
      out_data.image_done <= op.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ($past(state) == BK_CLEAR && state != BK_CLEAR) |->
      ($past(clr_cnt) == ADDR_W'(MAX_OUT_COLUMNS - 1)))
    else $error("clearing pass ended early");
  assert property (@(posedge clk) disable iff (rst) (state == BK_DIVIDE) |-> op.emit)
    else $error("divide started for a non-emitting operation");

endmodule

>>> sv/box_average_downsampler.sv
// Channel  Direction  Handshake           Payload
// cfg      in         cfg_write           cfg_index, cfg_data (register write)
// in       in         in_valid/in_stall   in_data: one source pixel, four bytes
// out      out        out_valid/out_stall out_data: block average, image_done
//
// A pixel outside every full block stays in the front end and is never queued.
// A pixel inside a block takes a sum memory read, then a write, in the back
// end, and the pixel that closes a block also runs the 16-step divide by the
// block area. A four-entry queue lets the front end run ahead. After reset
// the sum memory is cleared one column per cycle, all MAX_OUT_COLUMNS columns,
// and no pixel is taken meanwhile. After reset and after every configuration
// write the front end rebuilds its block geometry before it takes pixels. The
// result register lets the back end finish a block while the previous result
// is still stalled.
module box_average_downsampler
  import bad_pkg::*;
#(
  parameter int MAX_OUT_COLUMNS = DEFAULT_MAX_OUT_COLUMNS,
  parameter int MAX_FACTOR      = DEFAULT_MAX_FACTOR
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pixel_t                 in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output result_t                out_data
);

  localparam int FACT_W = $clog2(MAX_FACTOR + 1);

  // Raw configuration registers, exactly as written.
  logic [DIM_W-1:0]      source_width;
  logic [DIM_W-1:0]      source_height;
  logic [RAW_FACT_W-1:0] shrink_factor;
  logic [CH_W-1:0]       channel_count;

  // Clamped values that the datapath works with.
  geom_t             geom;
  logic [FACT_W-1:0] factor;
  logic [CH_W-1:0]   channels;

  // Queue between the front end and the back end.
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  op_t  q_in;
  op_t  q_head;
  logic clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_WIDTH;
      source_height <= RESET_HEIGHT;
      shrink_factor <= RESET_FACTOR;
      channel_count <= RESET_CHANNELS;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_SHRINK_FACTOR: shrink_factor <= cfg_data[RAW_FACT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero means one everywhere; oversize values saturate to their limits.
  always_comb begin
    geom.width  = clamp_dim(source_width);
    geom.height = clamp_dim(source_height);
    channels    = clamp_channels(channel_count);
    if (shrink_factor == '0) begin
      factor = FACT_W'(1);
    end else if (32'(shrink_factor) > MAX_FACTOR) begin
      factor = FACT_W'(MAX_FACTOR);
    end else begin
      factor = FACT_W'(shrink_factor);
    end
  end

  // The front end tracks the raster position and decides, per transaction,
  // whether the pixel lands in a full block and whether it closes one.
  bad_front #(
    .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .resync(cfg_write),
    .geom(geom),
    .factor(factor),
    .clearing(clearing),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .q_push(q_push),
    .q_op(q_in),
    .q_full(q_full)
  );

  bad_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_op(q_in),
    .pop(q_pop),
    .head_op(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  // The back end owns the per-column sum memory, does the read-modify-write,
  // and divides a finished block by its area before handing it out.
  bad_back #(
    .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .channels(channels),
    .factor(factor),
    .q_empty(q_empty),
    .q_op(q_head),
    .q_pop(q_pop),
    .clearing(clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
